// ===== hdl/wuf_pkg.sv =====
// ----------------------------------------------------------------------------
// wuf_pkg
// Shared constants, types and state codes of the weighted union-find engine.
// ----------------------------------------------------------------------------
package wuf_pkg;

  localparam int NODES   = 1024;
  localparam int NODE_W  = $clog2(NODES);
  localparam int COUNT_W = 11;
  localparam int SIZE_W  = $clog2(NODES + 1);
  localparam int QDEPTH  = 2;
  localparam int QPTR_W  = $clog2(QDEPTH);

  localparam logic OP_QUERY = 1'b0;
  localparam logic OP_UNION = 1'b1;

  // One classified item on its way from the front part to the back part.
  typedef struct packed {
    logic              operation;
    logic [NODE_W-1:0] node_a;
    logic [NODE_W-1:0] node_b;
    logic              index_error;
  } wuf_cmd_t;

  // Front part to back part.
  typedef struct packed {
    logic               init;
    logic [COUNT_W-1:0] node_count;
  } wuf_ctrl_t;

  // Back part to front part.
  typedef struct packed {
    logic clearing;
  } wuf_stat_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WALK_A,
    ST_WALK_B,
    ST_SIZE_A,
    ST_SIZE_B,
    ST_EMIT
  } wuf_state_t;

endpackage

// ===== hdl/wuf_ifs.sv =====
// ----------------------------------------------------------------------------
// wuf channel interfaces
// Valid/ready channels for items in, results out and the node count register.
// ----------------------------------------------------------------------------
interface wuf_in_if import wuf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              operation;
  logic [NODE_W-1:0] node_a;
  logic [NODE_W-1:0] node_b;

  modport source (output valid, operation, node_a, node_b, input ready);
  modport sink   (input valid, operation, node_a, node_b, output ready);
endinterface

interface wuf_out_if import wuf_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               same_set;
  logic               merged;
  logic [COUNT_W-1:0] components;
  logic               index_error;

  modport source (output valid, same_set, merged, components, index_error, input ready);
  modport sink   (input valid, same_set, merged, components, index_error, output ready);
endinterface

interface wuf_cfg_if import wuf_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [COUNT_W-1:0] node_count;

  modport source (output valid, node_count, input ready);
  modport sink   (input valid, node_count, output ready);
endinterface

// ===== hdl/wuf_ram.sv =====
// ----------------------------------------------------------------------------
// wuf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module wuf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/wuf_front.sv =====
// ----------------------------------------------------------------------------
// wuf_front
// Takes items and node count writes, range-checks the node indices.
// ----------------------------------------------------------------------------
module wuf_front import wuf_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  wuf_in_if.sink        in_if,
  wuf_cfg_if.sink       cfg_if,
  input  wuf_stat_t     stat,
  output wuf_ctrl_t     ctrl,
  output logic          push_valid,
  input  logic          push_ready,
  output wuf_cmd_t      push_cmd
);

  logic [COUNT_W-1:0] node_count_r, node_count_nxt;
  logic               init_r, init_nxt;
  logic               cfg_fire;

  // A zero count becomes one, anything above the store size becomes the size.
  function automatic logic [COUNT_W-1:0] clamp_count(input logic [COUNT_W-1:0] v);
    logic [COUNT_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = COUNT_W'(1);
    end else if (v > COUNT_W'(NODES)) begin
      r = COUNT_W'(NODES);
    end
    return r;
  endfunction

  assign cfg_if.ready = 1'b1;
  assign cfg_fire     = cfg_if.valid;

  always_comb begin
    node_count_nxt = node_count_r;
    if (cfg_fire) begin
      node_count_nxt = clamp_count(cfg_if.node_count);
    end
    init_nxt = cfg_fire;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= COUNT_W'(NODES);
      init_r       <= 1'b0;
    end else begin
      node_count_r <= node_count_nxt;
      init_r       <= init_nxt;
    end
  end

  // Hold items off while the store is being rebuilt.
  assign in_if.ready = push_ready && !stat.clearing && !init_r && !cfg_if.valid;
  assign push_valid  = in_if.valid && in_if.ready;

  always_comb begin
    push_cmd.operation   = in_if.operation;
    push_cmd.node_a      = in_if.node_a;
    push_cmd.node_b      = in_if.node_b;
    push_cmd.index_error = ({1'b0, in_if.node_a} >= node_count_r) ||
                           ({1'b0, in_if.node_b} >= node_count_r);
  end

  assign ctrl.init       = init_r;
  assign ctrl.node_count = node_count_r;

endmodule

// ===== hdl/wuf_queue.sv =====
// ----------------------------------------------------------------------------
// wuf_queue
// Short command queue between the front part and the back part.
// ----------------------------------------------------------------------------
module wuf_queue import wuf_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push_valid,
  output logic     push_ready,
  input  wuf_cmd_t push_cmd,
  output logic     pop_valid,
  input  logic     pop_ready,
  output wuf_cmd_t pop_cmd
);

  wuf_cmd_t            entry_r [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]     count_r, count_nxt;
  logic                do_push, do_pop;

  assign push_ready = (count_r != (QPTR_W+1)'(QDEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_cmd    = entry_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r + (QPTR_W+1)'(do_push) - (QPTR_W+1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// ===== hdl/wuf_back.sv =====
// ----------------------------------------------------------------------------
// wuf_back
// Root walks, weighted linking, set counting and the result register.
// ----------------------------------------------------------------------------
module wuf_back import wuf_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  wuf_ctrl_t  ctrl,
  output wuf_stat_t  stat,
  input  logic       pop_valid,
  output logic       pop_ready,
  input  wuf_cmd_t   pop_cmd,
  wuf_out_if.source  out_if
);

  wuf_state_t state_r, state_nxt;

  wuf_cmd_t           cmd_r, cmd_nxt;
  logic [NODE_W-1:0]  cur_r, cur_nxt;
  logic [NODE_W-1:0]  ra_r, ra_nxt;
  logic [NODE_W-1:0]  rb_r, rb_nxt;
  logic [NODE_W-1:0]  clr_r, clr_nxt;
  logic [SIZE_W-1:0]  sa_r, sa_nxt;
  logic [COUNT_W-1:0] total_r, total_nxt;
  logic               same_r, same_nxt;
  logic               merged_r, merged_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic               out_same_r, out_same_nxt;
  logic               out_merged_r, out_merged_nxt;
  logic [COUNT_W-1:0] out_comp_r, out_comp_nxt;
  logic               out_err_r, out_err_nxt;

  logic               p_we, s_we;
  logic [NODE_W-1:0]  p_waddr, p_raddr, p_wdata, p_rdata;
  logic [NODE_W-1:0]  s_waddr, s_raddr;
  logic [SIZE_W-1:0]  s_wdata, s_rdata;
  logic [SIZE_W-1:0]  size_sum;

  logic clr_last, root_hit, out_free;

  assign clr_last = (clr_r == NODE_W'(NODES - 1));
  assign root_hit = (p_rdata == cur_r);
  assign out_free = !out_valid_r || out_if.ready;
  assign size_sum = sa_r + s_rdata;

  wuf_ram #(.WIDTH(NODE_W), .DEPTH(NODES)) u_parent (
    .clk   (clk),
    .we    (p_we),
    .waddr (p_waddr),
    .wdata (p_wdata),
    .raddr (p_raddr),
    .rdata (p_rdata)
  );

  wuf_ram #(.WIDTH(SIZE_W), .DEPTH(NODES)) u_size (
    .clk   (clk),
    .we    (s_we),
    .waddr (s_waddr),
    .wdata (s_wdata),
    .raddr (s_raddr),
    .rdata (s_rdata)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (clr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (pop_valid) state_nxt = pop_cmd.index_error ? ST_EMIT : ST_WALK_A;
      end
      ST_WALK_A: begin
        if (root_hit) state_nxt = ST_WALK_B;
      end
      ST_WALK_B: begin
        if (root_hit) begin
          if ((cur_r == ra_r) || (cmd_r.operation == OP_QUERY)) begin
            state_nxt = ST_EMIT;
          end else begin
            state_nxt = ST_SIZE_A;
          end
        end
      end
      ST_SIZE_A: state_nxt = ST_SIZE_B;
      ST_SIZE_B: state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_CLEAR;
    endcase
    if (ctrl.init) state_nxt = ST_CLEAR;
  end

  // Datapath and memory control.
  always_comb begin
    cmd_nxt        = cmd_r;
    cur_nxt        = cur_r;
    ra_nxt         = ra_r;
    rb_nxt         = rb_r;
    clr_nxt        = clr_r;
    sa_nxt         = sa_r;
    total_nxt      = total_r;
    same_nxt       = same_r;
    merged_nxt     = merged_r;
    out_valid_nxt  = out_valid_r && !out_if.ready;
    out_same_nxt   = out_same_r;
    out_merged_nxt = out_merged_r;
    out_comp_nxt   = out_comp_r;
    out_err_nxt    = out_err_r;
    pop_ready      = 1'b0;
    p_we           = 1'b0;
    p_waddr        = clr_r;
    p_wdata        = clr_r;
    p_raddr        = cur_r;
    s_we           = 1'b0;
    s_waddr        = clr_r;
    s_wdata        = SIZE_W'(1);
    s_raddr        = ra_r;

    case (state_r)
      ST_CLEAR: begin
        p_we    = 1'b1;
        s_we    = 1'b1;
        clr_nxt = clr_r + NODE_W'(1);
        if (clr_last) total_nxt = ctrl.node_count;
      end
      ST_IDLE: begin
        pop_ready = 1'b1;
        if (pop_valid) begin
          cmd_nxt    = pop_cmd;
          cur_nxt    = pop_cmd.node_a;
          p_raddr    = pop_cmd.node_a;
          same_nxt   = 1'b0;
          merged_nxt = 1'b0;
        end
      end
      ST_WALK_A: begin
        if (root_hit) begin
          ra_nxt  = cur_r;
          cur_nxt = cmd_r.node_b;
          p_raddr = cmd_r.node_b;
        end else begin
          cur_nxt = p_rdata;
          p_raddr = p_rdata;
        end
      end
      ST_WALK_B: begin
        if (root_hit) begin
          rb_nxt   = cur_r;
          same_nxt = (cur_r == ra_r);
          s_raddr  = ra_r;
        end else begin
          cur_nxt = p_rdata;
          p_raddr = p_rdata;
        end
      end
      ST_SIZE_A: begin
        sa_nxt  = s_rdata;
        s_raddr = rb_r;
      end
      ST_SIZE_B: begin
        // The smaller tree goes under the larger; on a tie b's root moves.
        p_we    = 1'b1;
        s_we    = 1'b1;
        s_wdata = size_sum;
        if (sa_r < s_rdata) begin
          p_waddr = ra_r;
          p_wdata = rb_r;
          s_waddr = rb_r;
        end else begin
          p_waddr = rb_r;
          p_wdata = ra_r;
          s_waddr = ra_r;
        end
        if (total_r != '0) total_nxt = total_r - COUNT_W'(1);
        merged_nxt = 1'b1;
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_same_nxt   = same_r;
          out_merged_nxt = merged_r;
          out_comp_nxt   = total_r;
          out_err_nxt    = cmd_r.index_error;
        end
      end
      default: begin
      end
    endcase

    if (ctrl.init) clr_nxt = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    cur_r        <= cur_nxt;
    ra_r         <= ra_nxt;
    rb_r         <= rb_nxt;
    sa_r         <= sa_nxt;
    total_r      <= total_nxt;
    same_r       <= same_nxt;
    merged_r     <= merged_nxt;
    out_same_r   <= out_same_nxt;
    out_merged_r <= out_merged_nxt;
    out_comp_r   <= out_comp_nxt;
    out_err_r    <= out_err_nxt;
  end

  assign stat.clearing      = (state_r == ST_CLEAR);
  assign out_if.valid       = out_valid_r;
  assign out_if.same_set    = out_same_r;
  assign out_if.merged      = out_merged_r;
  assign out_if.components  = out_comp_r;
  assign out_if.index_error = out_err_r;

endmodule

// ===== hdl/weighted_union_find.sv =====
// ----------------------------------------------------------------------------
// weighted_union_find
// Disjoint-set engine: weighted quick-union with connectivity queries.
// ----------------------------------------------------------------------------
//   port     dir  payload                                     use
//   in_if    in   operation, node_a, node_b                   one item per op
//   out_if   out  same_set, merged, components, index_error   one item per op
//   cfg_if   in   node_count                                  rebuilds all sets
//
// An item with an out-of-range index goes straight to its result; otherwise
// the engine walks node_a and then node_b to their roots, and a union that
// links then reads both root sizes and writes the link; each parent link
// costs one read of the parent RAM. After reset and after every node_count
// write a clearing pass rewrites both RAMs, and no item is taken during it.
// A two-entry queue decouples intake from the walk engine; a stalled result
// holds the walk engine in place while further items wait in the queue.
// ----------------------------------------------------------------------------
module weighted_union_find import wuf_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  wuf_in_if.sink    in_if,
  wuf_out_if.source out_if,
  wuf_cfg_if.sink   cfg_if
);

  wuf_ctrl_t ctrl;
  wuf_stat_t stat;
  logic      push_valid, push_ready;
  logic      pop_valid, pop_ready;
  wuf_cmd_t  push_cmd, pop_cmd;

  wuf_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_if      (in_if),
    .cfg_if     (cfg_if),
    .stat       (stat),
    .ctrl       (ctrl),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd)
  );

  wuf_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_cmd    (pop_cmd)
  );

  wuf_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (ctrl),
    .stat      (stat),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_cmd   (pop_cmd),
    .out_if    (out_if)
  );

endmodule
